// ===== sv/pidh_pkg.sv =====
// Shared types and constants for the PID heading controller.
package pidh_pkg;

  localparam int ANGLE_W    = 23;
  localparam int ERR_W      = 24;
  localparam int DER_W      = 25;
  localparam int INTEG_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int IZONE_W    = 22;
  localparam int BAND_W     = 16;
  localparam int COUNT_W    = 8;
  localparam int POWER_W    = 15;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;
  localparam int                 POWER_LIMIT = 10000;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = 32'sh8000_0000;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET   = 3'd0,
    REG_GAIN_P   = 3'd1,
    REG_GAIN_I   = 3'd2,
    REG_GAIN_D   = 3'd3,
    REG_IZONE    = 3'd4,
    REG_BAND     = 3'd5,
    REG_PASSES   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] target;
    logic [GAIN_W-1:0]         gain_p;
    logic [GAIN_W-1:0]         gain_i;
    logic [GAIN_W-1:0]         gain_d;
    logic [IZONE_W-1:0]        izone;
    logic [BAND_W-1:0]         band;
    logic [COUNT_W-1:0]        passes;
  } cfg_t;

  // Per-item terms handed from the state stage to the multiply stage
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DER_W-1:0]   der;
    logic                      active;
    logic                      done;
  } stage_t;

endpackage

// ===== sv/pid_heading_controller_unit.sv =====
// Top level of the PID heading controller with integral zone and settle counter.
//
// Input channel in_*: one heading sample per item. in_tdata carries the measured
// heading (signed, hundredths of a degree); in_tuser carries new_turn, which
// clears error history, integral, settle count and done before the sample.
// Result channel out_*: one result per item with drive power (hundredths of a
// percent, saturated to +-10000), heading error and the done flag.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_addr; the user
// must write only while no items are in flight, the block does not enforce it.
// Path: an item passes the input, state, product, sum and result registers in order.
// Throughput: one item per cycle while out_tready stays high; the state update
// (error, integral, count) is a single registered step, multiplies and the rounding
// sum follow in their own pipeline stages.
// Reset: configuration returns to its defaults, all controller state and
// pipeline valid flags clear.
// Stall: when out_tready is low the result holds and the pipeline fills up;
// in_tready drops only once every stage holds an item.
module pid_heading_controller_unit import pidh_pkg::*; #(
  parameter int GAIN_FRACTION_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // [22:0] measured_angle
  input  logic                  in_tuser,   // [0] new_turn
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // [14:0] drive_power, [38:15] heading_error
  output logic                  out_tuser,  // [0] done_res
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PP_W  = GAIN_W + 1 + ERR_W;
  localparam int PI_W  = GAIN_W + 1 + INTEG_W;
  localparam int PD_W  = GAIN_W + 1 + DER_W;
  localparam int SUM_W = PI_W + 2;
  localparam logic [SUM_W-1:0] HALF  = SUM_W'(1) << (GAIN_FRACTION_BITS - 1);
  localparam logic [SUM_W-1:0] LIMIT = SUM_W'(POWER_LIMIT);

  cfg_t cfg_r;

  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic rdy1, rdy2, rdy3, rdy4, rdyo;

  logic signed [ANGLE_W-1:0] s1_meas_r;
  logic                      s1_nt_r;
  stage_t                    s2;

  logic signed [PP_W-1:0]  pp_r, pp_nxt;
  logic signed [PI_W-1:0]  pi_r, pi_nxt;
  logic signed [PD_W-1:0]  pd_r, pd_nxt;
  logic signed [ERR_W-1:0] s3_err_r, s4_err_r;
  logic                    s3_active_r, s4_active_r;
  logic                    s3_done_r, s4_done_r;

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0]        sum_mag, q;
  logic signed [POWER_W-1:0] power;

  logic signed [POWER_W-1:0] out_power_r;
  logic signed [ERR_W-1:0]   out_err_r;
  logic                      out_done_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= '0;
      cfg_r.gain_p <= 16'd184;
      cfg_r.gain_i <= 16'd0;
      cfg_r.gain_d <= 16'd31;
      cfg_r.izone  <= 22'd1000;
      cfg_r.band   <= 16'd100;
      cfg_r.passes <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_TARGET: cfg_r.target <= cfg_wdata[ANGLE_W-1:0];
        REG_GAIN_P: cfg_r.gain_p <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I: cfg_r.gain_i <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D: cfg_r.gain_d <= cfg_wdata[GAIN_W-1:0];
        REG_IZONE:  cfg_r.izone  <= cfg_wdata[IZONE_W-1:0];
        REG_BAND:   cfg_r.band   <= cfg_wdata[BAND_W-1:0];
        REG_PASSES: cfg_r.passes <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage readiness: a stage moves on when its successor is empty or moving
  assign rdyo      = !vo_r || out_tready;
  assign rdy4      = !v4_r || rdyo;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdyo) vo_r <= v4_r;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_meas_r <= in_tdata[ANGLE_W-1:0];
      s1_nt_r   <= in_tuser;
    end
  end

  // State update
  pidh_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (v1_r && rdy2),
    .new_turn (s1_nt_r),
    .meas     (s1_meas_r),
    .cfg      (cfg_r),
    .stage_r  (s2)
  );

  // Three gain products
  assign pp_nxt = $signed({1'b0, cfg_r.gain_p}) * s2.err;
  assign pi_nxt = $signed({1'b0, cfg_r.gain_i}) * s2.integ;
  assign pd_nxt = $signed({1'b0, cfg_r.gain_d}) * s2.der;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      pp_r        <= pp_nxt;
      pi_r        <= pi_nxt;
      pd_r        <= pd_nxt;
      s3_err_r    <= s2.err;
      s3_active_r <= s2.active;
      s3_done_r   <= s2.done;
    end
  end

  // Exact sum of the products
  assign sum_nxt = {{(SUM_W-PP_W){pp_r[PP_W-1]}}, pp_r}
                 + {{(SUM_W-PI_W){pi_r[PI_W-1]}}, pi_r}
                 + {{(SUM_W-PD_W){pd_r[PD_W-1]}}, pd_r};

  always_ff @(posedge clk) begin
    if (rdy4) begin
      sum_r       <= sum_nxt;
      s4_err_r    <= s3_err_r;
      s4_active_r <= s3_active_r;
      s4_done_r   <= s3_done_r;
    end
  end

  // Round half away from zero, then saturate; inactive items give zero power
  assign sum_mag = sum_r[SUM_W-1] ? (-sum_r) : sum_r;
  assign q       = (sum_mag + HALF) >> GAIN_FRACTION_BITS;

  always_comb begin
    if (!s4_active_r) begin
      power = '0;
    end else if (q > LIMIT) begin
      power = sum_r[SUM_W-1] ? -POWER_W'(POWER_LIMIT) : POWER_W'(POWER_LIMIT);
    end else begin
      power = sum_r[SUM_W-1] ? -q[POWER_W-1:0] : q[POWER_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rdyo) begin
      out_power_r <= power;
      out_err_r   <= s4_err_r;
      out_done_r  <= s4_done_r;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {1'b0, out_err_r, out_power_r};
  assign out_tuser  = out_done_r;

endmodule

// ===== sv/pidh_state.sv =====
// Error, integral, derivative and settle-count state update for the heading controller.
module pidh_state import pidh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      new_turn,
  input  logic signed [ANGLE_W-1:0] meas,
  input  cfg_t                      cfg,
  output stage_t                    stage_r
);

  logic signed [ERR_W-1:0]   prev_r, prev_cur, prev_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_cur, integ_nxt;
  logic [COUNT_W-1:0]        count_r, count_cur, count_nxt, count_inc;
  logic                      fin_r, fin_cur, fin_nxt;

  logic signed [ERR_W-1:0]   err;
  logic [ERR_W-1:0]          err_mag;
  logic                      in_band, in_zone;
  logic signed [INTEG_W:0]   acc;
  logic signed [DER_W-1:0]   der;
  logic                      active;

  // Heading error and its magnitude
  assign err     = {cfg.target[ANGLE_W-1], cfg.target} - {meas[ANGLE_W-1], meas};
  assign err_mag = err[ERR_W-1] ? (-err) : err;
  assign in_band = err_mag < {{(ERR_W-BAND_W){1'b0}}, cfg.band};
  assign in_zone = err_mag < {{(ERR_W-IZONE_W){1'b0}}, cfg.izone};

  // new_turn clears history before this item is processed
  assign prev_cur  = new_turn ? '0 : prev_r;
  assign integ_cur = new_turn ? '0 : integ_r;
  assign count_cur = new_turn ? '0 : count_r;
  assign fin_cur   = new_turn ? 1'b0 : fin_r;

  assign count_inc = (count_cur == COUNT_MAX) ? count_cur : count_cur + 1'b1;
  assign acc = {integ_cur[INTEG_W-1], integ_cur}
             + {{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};

  // Settle check, then integral and derivative while the turn runs
  always_comb begin
    prev_nxt  = prev_cur;
    integ_nxt = integ_cur;
    count_nxt = count_cur;
    fin_nxt   = fin_cur;
    der       = '0;
    active    = 1'b0;
    if (!fin_cur) begin
      if (in_band) begin
        count_nxt = count_inc;
        if (count_inc >= cfg.passes) fin_nxt = 1'b1;
      end
      if (!fin_nxt) begin
        active = 1'b1;
        if (in_zone) begin
          if (acc[INTEG_W] != acc[INTEG_W-1]) begin
            integ_nxt = acc[INTEG_W] ? INTEG_MIN : INTEG_MAX;
          end else begin
            integ_nxt = acc[INTEG_W-1:0];
          end
        end
        der      = {err[ERR_W-1], err} - {prev_cur[ERR_W-1], prev_cur};
        prev_nxt = err;
      end
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      integ_r <= '0;
      count_r <= '0;
      fin_r   <= 1'b0;
    end else if (en) begin
      prev_r  <= prev_nxt;
      integ_r <= integ_nxt;
      count_r <= count_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // Terms for the multiply stage
  always_ff @(posedge clk) begin
    if (en) begin
      stage_r.err    <= err;
      stage_r.integ  <= integ_nxt;
      stage_r.der    <= der;
      stage_r.active <= active;
      stage_r.done   <= fin_nxt;
    end
  end

endmodule
